### hw/rtl/phf_pkg.sv
// Shared types and codes for the packet header filter.
// Used by packet_header_filter and its port checker; no dependencies.

package phf_pkg;

   // Default saturation point of the per-frame byte count
   localparam int unsigned MAX_FRAME_BYTES_DEF = 65535;

   // Byte positions inside the Ethernet frame
   localparam logic [15:0] IP_START  = 16'd14;
   localparam logic [15:0] PROTO_POS = 16'd23;
   localparam logic [15:0] SRC_POS   = 16'd26;
   localparam logic [15:0] DST_POS   = 16'd30;

   // IPv4 protocol numbers
   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;

   // Reported protocol class
   localparam logic [1:0] CLASS_ICMP  = 2'd0;
   localparam logic [1:0] CLASS_TCP   = 2'd1;
   localparam logic [1:0] CLASS_UDP   = 2'd2;
   localparam logic [1:0] CLASS_OTHER = 2'd3;

   // Protocol mode register values
   localparam logic [1:0] MODE_ANY  = 2'd0;
   localparam logic [1:0] MODE_TCP  = 2'd1;
   localparam logic [1:0] MODE_UDP  = 2'd2;
   localparam logic [1:0] MODE_ICMP = 2'd3;

   // Register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_PROTO_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDR_ON     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDR_VALUE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_ON     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_VALUE  = 3'd4;

   // Smallest frame that can ever pass the length check
   localparam logic [15:0] MIN_NEED_BYTES = 16'd24;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [1:0]  proto_class;
      logic [31:0] source_address;
      logic [31:0] target_address;
      logic [15:0] source_port;
      logic [15:0] target_port;
      logic [5:0]  tcp_flag_bits;
      logic [15:0] frame_bytes;
      logic        too_short;
      logic [31:0] seen_count;
      logic [31:0] accept_count;
   } rsp_type;

endpackage

### hw/rtl/packet_header_filter.sv
// Ethernet / IPv4 / layer-4 header filter, one frame byte per item.
// Depends on phf_pkg for payload structs, positions and codes.
//
//   channel   direction  payload              handshake
//   req_      in         phf_pkg::req_type    req_valid / req_stall
//   rsp_      out        phf_pkg::rsp_type    rsp_valid / rsp_stall
//   csr_      in         index + 32-bit data  csr_we, no read-back
//
// One byte is taken every cycle unless req_stall holds it. A byte waits in the input
// register, then updates the frame capture state; the final byte also loads the verdict
// into the result register, so a verdict shows after its last byte leaves the input register.
// Reset is synchronous; it clears valids, frame state and counters (not the data registers); no clearing pass.
// A held verdict stalls the input only when the next final byte reaches it.

module packet_header_filter #(
   parameter int unsigned MAX_FRAME_BYTES = phf_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  phf_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output phf_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [phf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                     csr_wdata
);

   localparam logic [15:0] MAX_BYTES = 16'(MAX_FRAME_BYTES);

   // Configuration registers
   logic [1:0]  proto_mode_ff;
   logic        addr_on_ff;
   logic [31:0] addr_value_ff;
   logic        port_on_ff;
   logic [15:0] port_value_ff;

   // Input register
   logic             s1_valid_ff;
   phf_pkg::req_type s1_data_ff;

   // Frame capture state
   logic [15:0] offset_ff,   offset_in;
   logic [3:0]  hwords_ff,   hwords_in;
   logic [7:0]  proto_ff,    proto_in;
   logic [31:0] src_addr_ff, src_addr_in;
   logic [31:0] dst_addr_ff, dst_addr_in;
   logic [15:0] src_port_ff, src_port_in;
   logic [15:0] dst_port_ff, dst_port_in;
   logic [5:0]  flags_ff,    flags_in;
   logic [31:0] seen_ff,     seen_in;
   logic [31:0] acc_ff,      acc_in;

   // Result register
   logic             rsp_valid_ff;
   phf_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic        out_free;
   logic        s1_go;
   logic        s1_load;
   logic        last_go;
   logic [7:0]  b;
   logic [6:0]  l4_cur;
   logic [6:0]  l4_new;
   logic [15:0] rel;
   logic        in_l4;
   logic [15:0] need;
   logic [1:0]  cls;
   logic        short_frame;
   logic        mode_ok;
   logic        addr_ok;
   logic        port_ok;
   logic        ok;

   function automatic logic [6:0] l4_of(input logic [3:0] hw);
      logic [3:0] h;
      h = (hw < 4'd5) ? 4'd5 : hw;
      return 7'd14 + {1'b0, h, 2'b00};
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && (!s1_data_ff.frame_end || out_free);
   assign s1_load   = req_valid && !req_stall;
   assign req_stall = s1_valid_ff && !s1_go;
   assign last_go   = s1_go && s1_data_ff.frame_end;
   assign b         = s1_data_ff.frame_byte;

   // Capture the byte into the frame state
   always_comb begin
      offset_in   = offset_ff;
      hwords_in   = hwords_ff;
      proto_in    = proto_ff;
      src_addr_in = src_addr_ff;
      dst_addr_in = dst_addr_ff;
      src_port_in = src_port_ff;
      dst_port_in = dst_port_ff;
      flags_in    = flags_ff;
      l4_cur      = l4_of(hwords_ff);
      in_l4       = offset_ff >= {9'd0, l4_cur};
      rel         = offset_ff - {9'd0, l4_cur};
      if (offset_ff < MAX_BYTES) begin
         offset_in = offset_ff + 16'd1;
         if (offset_ff == phf_pkg::IP_START) begin
            hwords_in = b[3:0];
         end
         if (offset_ff == phf_pkg::PROTO_POS) begin
            proto_in = b;
         end
         if (offset_ff >= phf_pkg::SRC_POS && offset_ff < phf_pkg::SRC_POS + 16'd4) begin
            src_addr_in = {src_addr_ff[23:0], b};
         end
         if (offset_ff >= phf_pkg::DST_POS && offset_ff < phf_pkg::DST_POS + 16'd4) begin
            dst_addr_in = {dst_addr_ff[23:0], b};
         end
         if (in_l4) begin
            if (rel < 16'd2) begin
               src_port_in = {src_port_ff[7:0], b};
            end else if (rel < 16'd4) begin
               dst_port_in = {dst_port_ff[7:0], b};
            end else if (rel == 16'd13) begin
               flags_in = b[5:0];
            end
         end
      end
   end

   // Verdict on the state as it stands after the final byte
   always_comb begin
      l4_new = l4_of(hwords_in);
      if (offset_in <= phf_pkg::PROTO_POS) begin
         cls = phf_pkg::CLASS_OTHER;
      end else if (proto_in == phf_pkg::PROTO_ICMP) begin
         cls = phf_pkg::CLASS_ICMP;
      end else if (proto_in == phf_pkg::PROTO_TCP) begin
         cls = phf_pkg::CLASS_TCP;
      end else if (proto_in == phf_pkg::PROTO_UDP) begin
         cls = phf_pkg::CLASS_UDP;
      end else begin
         cls = phf_pkg::CLASS_OTHER;
      end

      unique case (cls)
         phf_pkg::CLASS_ICMP: need = phf_pkg::DST_POS + 16'd4;
         phf_pkg::CLASS_TCP:  need = {9'd0, l4_new} + 16'd14;
         phf_pkg::CLASS_UDP:  need = {9'd0, l4_new} + 16'd4;
         default:             need = phf_pkg::PROTO_POS + 16'd1;
      endcase
      short_frame = offset_in < need;

      rsp_data_in = '0;
      rsp_data_in.proto_class    = cls;
      rsp_data_in.source_address = src_addr_in;
      rsp_data_in.target_address = dst_addr_in;
      if (cls == phf_pkg::CLASS_TCP || cls == phf_pkg::CLASS_UDP) begin
         rsp_data_in.source_port = src_port_in;
         rsp_data_in.target_port = dst_port_in;
      end
      if (cls == phf_pkg::CLASS_TCP) begin
         rsp_data_in.tcp_flag_bits = flags_in;
      end

      unique case (proto_mode_ff)
         phf_pkg::MODE_TCP:  mode_ok = cls == phf_pkg::CLASS_TCP;
         phf_pkg::MODE_UDP:  mode_ok = cls == phf_pkg::CLASS_UDP;
         phf_pkg::MODE_ICMP: mode_ok = cls == phf_pkg::CLASS_ICMP;
         default:            mode_ok = 1'b1;
      endcase
      addr_ok = !addr_on_ff || src_addr_in == addr_value_ff || dst_addr_in == addr_value_ff;
      port_ok = !port_on_ff || cls == phf_pkg::CLASS_ICMP
                || rsp_data_in.source_port == port_value_ff
                || rsp_data_in.target_port == port_value_ff;
      ok = !short_frame && cls != phf_pkg::CLASS_OTHER && mode_ok && addr_ok && port_ok;

      seen_in = seen_ff + 32'd1;
      acc_in  = ok ? acc_ff + 32'd1 : acc_ff;

      rsp_data_in.accepted     = ok;
      rsp_data_in.frame_bytes  = offset_in;
      rsp_data_in.too_short    = short_frame;
      rsp_data_in.seen_count   = seen_in;
      rsp_data_in.accept_count = acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         proto_mode_ff <= phf_pkg::MODE_ANY;
         addr_on_ff    <= 1'b0;
         addr_value_ff <= '0;
         port_on_ff    <= 1'b0;
         port_value_ff <= 16'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            phf_pkg::CSR_PROTO_MODE: proto_mode_ff <= csr_wdata[1:0];
            phf_pkg::CSR_ADDR_ON:    addr_on_ff    <= csr_wdata[0];
            phf_pkg::CSR_ADDR_VALUE: addr_value_ff <= csr_wdata;
            phf_pkg::CSR_PORT_ON:    port_on_ff    <= csr_wdata[0];
            phf_pkg::CSR_PORT_VALUE: port_value_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= '0;
         hwords_ff   <= '0;
         proto_ff    <= '0;
         src_addr_ff <= '0;
         dst_addr_ff <= '0;
         src_port_ff <= '0;
         dst_port_ff <= '0;
         flags_ff    <= '0;
         seen_ff     <= '0;
         acc_ff      <= '0;
      end else if (last_go) begin
         // drop per-frame state, advance the counters
         offset_ff   <= '0;
         hwords_ff   <= '0;
         proto_ff    <= '0;
         src_addr_ff <= '0;
         dst_addr_ff <= '0;
         src_port_ff <= '0;
         dst_port_ff <= '0;
         flags_ff    <= '0;
         seen_ff     <= seen_in;
         acc_ff      <= acc_in;
      end else if (s1_go) begin
         offset_ff   <= offset_in;
         hwords_ff   <= hwords_in;
         proto_ff    <= proto_in;
         src_addr_ff <= src_addr_in;
         dst_addr_ff <= dst_addr_in;
         src_port_ff <= src_port_in;
         dst_port_ff <= dst_port_in;
         flags_ff    <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (last_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (last_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### hw/rtl/phf_checker.sv
// Port-level checks for packet_header_filter, attached by bind below.
// Depends on phf_pkg for payload structs and class codes.

module phf_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input phf_pkg::rsp_type rsp_data
);

   // hold a stalled verdict
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled verdict changed");

   a_accept_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.accepted |->
         !rsp_data.too_short && rsp_data.proto_class != phf_pkg::CLASS_OTHER)
      else $error("accepted a short or unknown frame");

   a_ports_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.proto_class == phf_pkg::CLASS_ICMP
                    || rsp_data.proto_class == phf_pkg::CLASS_OTHER) |->
         rsp_data.source_port == 16'd0 && rsp_data.target_port == 16'd0
         && rsp_data.tcp_flag_bits == 6'd0)
      else $error("ports or flags set for a portless protocol");

   a_short_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_bytes < phf_pkg::MIN_NEED_BYTES |-> rsp_data.too_short)
      else $error("tiny frame not flagged short");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("verdict shown right after reset");

endmodule

bind packet_header_filter phf_checker u_phf_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
